/* sv/trial_division_prime_test_core_macros.svh */
// Assertion macros shared by the checker of the prime test core.
`ifndef TRIAL_DIVISION_PRIME_TEST_CORE_MACROS_SVH
`define TRIAL_DIVISION_PRIME_TEST_CORE_MACROS_SVH

// Next-cycle implication, ignored while reset is asserted.
`define TDPT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tdpt checker: next-cycle property failed");

// Next-cycle implication that also holds across reset.
`define TDPT_ASSERT_NEXT_RST(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("tdpt checker: reset property failed");

`endif

/* sv/tdpt_pkg.sv */
// Shared widths, constants and control/status types of the prime test core.
package tdpt_pkg;

  localparam int VALUE_WIDTH = 32;
  // Divisors never pass sqrt(2^(VALUE_WIDTH-1)) + 6, which fits here.
  localparam int D_W   = VALUE_WIDTH / 2 + 3;
  localparam int SQ_W  = VALUE_WIDTH + 1;
  localparam int CNT_W = $clog2(VALUE_WIDTH + 1);

  localparam logic [VALUE_WIDTH-1:0] VAL_ONE   = VALUE_WIDTH'(1);
  localparam logic [VALUE_WIDTH-1:0] VAL_THREE = VALUE_WIDTH'(3);
  localparam logic [D_W-1:0]  DIV_TWO   = D_W'(2);
  localparam logic [D_W-1:0]  DIV_THREE = D_W'(3);
  localparam logic [D_W-1:0]  D_FIRST   = D_W'(5);
  localparam logic [D_W-1:0]  D_GAP     = D_W'(2);
  localparam logic [D_W-1:0]  D_STEP    = D_W'(6);
  localparam logic [SQ_W-1:0] SQ_FIRST  = SQ_W'(25);
  localparam logic [SQ_W-1:0] SQ_BIAS   = SQ_W'(36);
  localparam logic [CNT_W-1:0] DIV_STEPS = CNT_W'(VALUE_WIDTH);

  typedef struct packed {
    logic load;
    logic start_small;
    logic start_pair;
    logic step;
    logic adv;
  } tdpt_cmd_t;

  typedef struct packed {
    logic neg;
    logic le1;
    logic le3;
    logic div_busy;
    logic rem_zero;
    logic sq_gt;
  } tdpt_stat_t;

endpackage

/* sv/tdpt_dp.sv */
// Datapath: operand, divisor/square tracking and two restoring remainder lanes.
module tdpt_dp
  import tdpt_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic signed [VALUE_WIDTH-1:0] in_value,
  input  tdpt_cmd_t                     cmd,
  output tdpt_stat_t                    stat
);

  logic [VALUE_WIDTH-1:0] n_r;
  logic [VALUE_WIDTH-1:0] sh_r;
  logic [D_W-1:0]         d_r;
  logic [SQ_W-1:0]        sq_r;
  logic                   pair_r;
  logic [D_W-1:0]         div0_r;
  logic [D_W-1:0]         div1_r;
  logic [D_W-1:0]         r0_r;
  logic [D_W-1:0]         r1_r;
  logic [CNT_W-1:0]       cnt_r;

  logic [D_W:0]   t0;
  logic [D_W:0]   t1;
  logic           ge0;
  logic           ge1;
  logic [D_W-1:0] r0_nxt;
  logic [D_W-1:0] r1_nxt;
  logic [SQ_W-1:0] d_ext;
  logic [SQ_W-1:0] sq_nxt;

  // One quotient bit per cycle in each lane, both fed from the same operand bit.
  assign t0  = {r0_r, sh_r[VALUE_WIDTH-1]};
  assign t1  = {r1_r, sh_r[VALUE_WIDTH-1]};
  assign ge0 = t0 >= {1'b0, div0_r};
  assign ge1 = t1 >= {1'b0, div1_r};
  assign r0_nxt = ge0 ? D_W'(t0 - {1'b0, div0_r}) : t0[D_W-1:0];
  assign r1_nxt = ge1 ? D_W'(t1 - {1'b0, div1_r}) : t1[D_W-1:0];

  // (d + 6)^2 = d^2 + 12d + 36, so the bound needs no multiplier.
  assign d_ext  = SQ_W'(d_r);
  assign sq_nxt = sq_r + (d_ext << 3) + (d_ext << 2) + SQ_BIAS;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      n_r    <= $unsigned(in_value);
      d_r    <= D_FIRST;
      sq_r   <= SQ_FIRST;
      pair_r <= 1'b0;
    end else if (cmd.adv && pair_r) begin
      d_r  <= d_r + D_STEP;
      sq_r <= sq_nxt;
    end
    if (cmd.start_small || cmd.start_pair) begin
      sh_r   <= n_r;
      r0_r   <= '0;
      r1_r   <= '0;
      pair_r <= cmd.start_pair;
      div0_r <= cmd.start_pair ? d_r : DIV_TWO;
      div1_r <= cmd.start_pair ? d_r + D_GAP : DIV_THREE;
    end else if (cmd.step && (cnt_r != '0)) begin
      sh_r <= {sh_r[VALUE_WIDTH-2:0], 1'b0};
      r0_r <= r0_nxt;
      r1_r <= r1_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.start_small || cmd.start_pair) begin
      cnt_r <= DIV_STEPS;
    end else if (cmd.step && (cnt_r != '0)) begin
      cnt_r <= cnt_r - CNT_W'(1);
    end
  end

  assign stat.neg      = n_r[VALUE_WIDTH-1];
  assign stat.le1      = n_r <= VAL_ONE;
  assign stat.le3      = n_r <= VAL_THREE;
  assign stat.div_busy = cnt_r != '0;
  assign stat.rem_zero = (r0_r == '0) || (r1_r == '0);
  assign stat.sq_gt    = sq_r > {1'b0, n_r};

endmodule

/* sv/tdpt_ctrl.sv */
// Controller: sequences the test of one value and holds the result register.
module tdpt_ctrl
  import tdpt_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_prime,
  output tdpt_cmd_t  cmd,
  input  tdpt_stat_t stat
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CLASS = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_EVAL  = 3'd3;
  localparam logic [2:0] S_CHECK = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0] state_r;
  logic [2:0] state_nxt;
  logic       res_r;
  logic       res_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;
  logic       out_prime_r;
  logic       load_out;

  always_comb begin
    state_nxt = state_r;
    res_nxt   = res_r;
    cmd       = '0;
    load_out  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CLASS;
        end
      end
      S_CLASS: begin
        priority if (stat.neg || stat.le1) begin
          res_nxt   = 1'b0;
          state_nxt = S_DONE;
        end else if (stat.le3) begin
          res_nxt   = 1'b1;
          state_nxt = S_DONE;
        end else begin
          cmd.start_small = 1'b1;
          state_nxt       = S_DIV;
        end
      end
      S_DIV: begin
        if (stat.div_busy) begin
          cmd.step = 1'b1;
        end else begin
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        if (stat.rem_zero) begin
          res_nxt   = 1'b0;
          state_nxt = S_DONE;
        end else begin
          cmd.adv   = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.sq_gt) begin
          res_nxt   = 1'b1;
          state_nxt = S_DONE;
        end else begin
          cmd.start_pair = 1'b1;
          state_nxt      = S_DIV;
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          load_out  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // The result register frees the core as soon as the answer is parked.
  always_comb begin
    priority if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    if (load_out) begin
      out_prime_r <= res_r;
    end
  end

  assign in_stall  = state_r != S_IDLE;
  assign out_valid = out_valid_r;
  assign out_prime = out_prime_r;

endmodule

/* sv/trial_division_prime_test_core.sv */
// Prime test core: one signed value in, one prime flag out per transaction.
// Values at or below one are not prime, two and three are, and otherwise the
// value is divided by 2 and 3 and then by the pairs 6k-1, 6k+1 from 5 upward
// while the divisor squared does not exceed it. Both divisors of a pair run in
// two restoring remainder lanes that retire one operand bit per cycle. One
// item is in work at a time; the result register lets the next transaction
// in while a result is unread.
module trial_division_prime_test_core
  import tdpt_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [VALUE_WIDTH-1:0] in_value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_prime
);

  tdpt_cmd_t  cmd;
  tdpt_stat_t stat;

  tdpt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_prime (out_prime),
    .cmd       (cmd),
    .stat      (stat)
  );

  tdpt_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_value (in_value),
    .cmd      (cmd),
    .stat     (stat)
  );

endmodule

/* sv/tdpt_checker.sv */
// Port-level checker for the prime test core and its bind.
`include "trial_division_prime_test_core_macros.svh"

module tdpt_checker
  import tdpt_pkg::*;
(
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic signed [VALUE_WIDTH-1:0] in_value,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic                          out_prime
);

  logic in_acc;
  logic in_held;
  logic out_held;

  assign in_acc   = in_valid && !in_stall;
  assign in_held  = in_valid && in_stall;
  assign out_held = out_valid && out_stall;

  // An accepted transaction keeps the core busy for at least the next cycle.
  `TDPT_ASSERT_NEXT(a_busy_after_accept, in_acc, in_stall)
  // No result can leave in the cycle right after an input is taken.
  `TDPT_ASSERT_NEXT(a_no_instant_result, in_acc && !out_valid, !out_valid)
  `TDPT_ASSERT_NEXT(a_input_held, in_held, in_valid && $stable(in_value))
  `TDPT_ASSERT_NEXT(a_result_held, out_held, out_valid && $stable(out_prime))
  `TDPT_ASSERT_NEXT_RST(a_reset_clears, !rst_n, !out_valid && !in_stall)

endmodule

bind trial_division_prime_test_core tdpt_checker u_tdpt_checker (.*);
